[src/ogp_pkg.sv]
`timescale 1ns / 1ps
package ogp_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned PosWidthDef    = 24;
  localparam int unsigned AtanLen        = 24;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 24;

  // inverse CORDIC gain, Q2.30
  localparam logic signed [31:0] CordicK = 32'sd652032874;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_DRIVE_ENABLE  = 3'd2,
    REG_SPEED_GAIN    = 3'd3,
    REG_TURN_GAIN     = 3'd4,
    REG_TICK_PERIOD   = 3'd5,
    REG_ARRIVE_RADIUS = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CM_ROTATE = 2'd0,
    CM_VECTOR = 2'd1
  } cordic_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_START,
    ST_ROT_WAIT,
    ST_VEC_START,
    ST_VEC_WAIT,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_MUL_E,
    ST_MUL_F,
    ST_MUL_G,
    ST_MUL_H,
    ST_MUL_I,
    ST_OUT
  } ogp_state_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  atan_entry = 32'd536870912;
      5'd1:  atan_entry = 32'd316933406;
      5'd2:  atan_entry = 32'd167458907;
      5'd3:  atan_entry = 32'd85004756;
      5'd4:  atan_entry = 32'd42667331;
      5'd5:  atan_entry = 32'd21354465;
      5'd6:  atan_entry = 32'd10680862;
      5'd7:  atan_entry = 32'd5340245;
      5'd8:  atan_entry = 32'd2670163;
      5'd9:  atan_entry = 32'd1335087;
      5'd10: atan_entry = 32'd667544;
      5'd11: atan_entry = 32'd333772;
      5'd12: atan_entry = 32'd166886;
      5'd13: atan_entry = 32'd83443;
      5'd14: atan_entry = 32'd41722;
      5'd15: atan_entry = 32'd20861;
      5'd16: atan_entry = 32'd10430;
      5'd17: atan_entry = 32'd5215;
      5'd18: atan_entry = 32'd2608;
      5'd19: atan_entry = 32'd1304;
      5'd20: atan_entry = 32'd652;
      5'd21: atan_entry = 32'd326;
      5'd22: atan_entry = 32'd163;
      5'd23: atan_entry = 32'd81;
      default: atan_entry = 32'd0;
    endcase
  endfunction

endpackage

[src/ogp_if.sv]
`timescale 1ns / 1ps
interface ogp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] meas_speed;
  logic signed [23:0] meas_turn_rate;
  modport source (output valid, meas_speed, meas_turn_rate, input ready);
  modport sink (input valid, meas_speed, meas_turn_rate, output ready);
endinterface

interface ogp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_speed;
  logic signed [23:0] cmd_turn_rate;
  logic               reached;
  logic signed [23:0] pose_x_out;
  logic signed [23:0] pose_y_out;
  logic        [15:0] heading_out;
  modport source (output valid, cmd_speed, cmd_turn_rate, reached, pose_x_out, pose_y_out,
                  heading_out, input ready);
  modport sink (input valid, cmd_speed, cmd_turn_rate, reached, pose_x_out, pose_y_out,
                heading_out, output ready);
endinterface

interface ogp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/ogp_cordic.sv]
`timescale 1ns / 1ps
module ogp_cordic
  import ogp_pkg::*;
#(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cordic_ctl_t        ctl_i,
  input  logic        [15:0] angle_i,
  input  logic signed [55:0] vx_i,
  input  logic signed [55:0] vy_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o,
  output logic        [31:0] angle_o
);

  localparam int unsigned CntW = $clog2(CordicSteps + 1);

  // 58 bits hold the vectoring operands (error << 16 plus gain growth)
  logic signed [57:0] x_q, y_q;
  logic signed [57:0] x_d, y_d;
  logic        [31:0] z_q, z_d;
  logic        [CntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  cordic_mode_e       mode_q, mode_d;
  logic               neg_q, neg_d;
  logic signed [57:0] xs, ys;
  logic        [31:0] at;
  logic               dir_pos;
  logic        [31:0] a32;

  always_comb begin
    xs      = x_q >>> cnt_q;
    ys      = y_q >>> cnt_q;
    at      = atan_entry(5'(cnt_q));
    dir_pos = (mode_q == CM_ROTATE) ? !z_q[31] : (y_q > 58'sd0);
    a32     = {angle_i, 16'd0};
    x_d = x_q; y_d = y_q; z_d = z_q; cnt_d = cnt_q; busy_d = busy_q;
    mode_d = mode_q; neg_d = neg_q;
    done_o = 1'b0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mode_d = ctl_i.mode;
      if (ctl_i.mode == CM_ROTATE) begin
        neg_d = (a32[31:30] == 2'd1) || (a32[31:30] == 2'd2);
        z_d   = neg_d ? a32 - 32'h8000_0000 : a32;
        x_d   = 58'(CordicK);
        y_d   = '0;
      end else begin
        neg_d = 1'b0;
        if (vx_i < 56'sd0) begin
          x_d = -58'(vx_i);
          y_d = -58'(vy_i);
          z_d = 32'h8000_0000;
        end else begin
          x_d = 58'(vx_i);
          y_d = 58'(vy_i);
          z_d = '0;
        end
      end
    end else if (busy_q) begin
      if (cnt_q == CntW'(CordicSteps)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (mode_q == CM_ROTATE) begin
          if (dir_pos) begin
            x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
          end else begin
            x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
          end
        end else begin
          if (dir_pos) begin
            x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at;
          end else begin
            x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at;
          end
        end
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  assign cos_o   = neg_q ? -x_q[31:0] : x_q[31:0];
  assign sin_o   = neg_q ? -y_q[31:0] : y_q[31:0];
  assign angle_o = z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= CM_ROTATE;
      neg_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= CntW'(CordicSteps))
    else $error("cordic counter past step count");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q || $past(ctl_i.start))
    else $error("cordic busy after done");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("cordic started while busy");

endmodule

[src/odometry_go_to_point.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_if   | in  | meas_speed[15:0], meas_turn_rate[23:0]
// out_if  | out | cmd_speed, cmd_turn_rate, reached, pose_x_out, pose_y_out, heading_out
// cfg_if  | in  | index[2:0], data[23:0]
// One tick runs a rotation and a vectoring pass on the shared CORDIC, then nine steps on
// one shared multiplier and a write-back step. A new request is accepted only once the
// previous tick is back in idle and its result has been taken.
// Reset is asynchronous, active low; pose and heading clear, registers take defaults.
// A pending result holds off the next request; config is accepted only while idle
// and wins over an input request in the same cycle.
module odometry_go_to_point
  import ogp_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef,
  parameter int unsigned POS_WIDTH    = PosWidthDef
) (
  input logic    clk_i,
  input logic    rst_ni,
  ogp_in_if.sink    in_if,
  ogp_out_if.source out_if,
  ogp_cfg_if.sink   cfg_if
);

  // error width covers both the destination and the pose
  localparam int unsigned ErrW = ((POS_WIDTH > 24) ? POS_WIDTH : 24) + 1;

  ogp_state_e state_q, state_d;

  logic signed [23:0] dest_x_q, dest_y_q;
  logic               drive_en_q;
  logic        [15:0] speed_gain_q, turn_gain_q, tick_q, radius_q;

  logic signed [POS_WIDTH-1:0] pose_x_q, pose_y_q;
  logic        [15:0]          heading_q;

  logic signed [15:0] spd_q;
  logic signed [23:0] rate_q;
  logic signed [31:0] cos_q, sin_q;
  logic signed [ErrW-1:0] ex_q, ey_q;
  logic               reached_q;
  logic signed [95:0] acc_q, acc_d;
  logic signed [47:0] tmp_q, tmp_d;

  logic               out_valid_q;
  logic signed [15:0] cs_q;
  logic signed [23:0] ct_q;

  cordic_ctl_t        cctl;
  logic               cdone;
  logic signed [31:0] ccos, csin;
  logic        [31:0] cang;
  logic signed [55:0] vx, vy;
  logic               in_fire;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [ErrW-1:0] dx_ext, dy_ext;
  assign dx_ext = ErrW'(dest_x_q);
  assign dy_ext = ErrW'(dest_y_q);
  assign vx = 56'(ex_q) <<< 16;
  assign vy = 56'(ey_q) <<< 16;

  assign in_fire = in_if.valid && in_if.ready;

  ogp_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .ctl_i(cctl), .angle_i(heading_q), .vx_i(vx), .vy_i(vy),
    .done_o(cdone), .cos_o(ccos), .sin_o(csin), .angle_o(cang)
  );

  logic        [31:0] bear;
  logic signed [31:0] err32;
  logic signed [63:0] proj;
  logic signed [32:0] projc;
  logic signed [63:0] cs_full;
  logic signed [63:0] ct_full;
  logic signed [47:0] hinc;

  always_comb begin
    state_d = state_q;
    cctl    = '{start: 1'b0, mode: CM_ROTATE};
    acc_d   = acc_q;
    tmp_d   = tmp_q;
    mul_a   = '0;
    mul_b   = '0;
    // at the destination the bearing is taken as zero
    bear    = (ex_q == '0 && ey_q == '0) ? 32'd0 : cang;
    err32   = $signed(bear - {heading_q, 16'd0});
    proj    = 64'(acc_q >>> 30);
    // a clamped projection still saturates the speed command
    projc   = (proj > 64'sd4294967295) ? 33'sh0_FFFF_FFFF :
              (proj < -64'sd4294967296) ? 33'sh1_0000_0000 : 33'(proj);
    cs_full = 64'(acc_q >>> 8);
    ct_full = 64'(acc_q >>> 24);
    hinc    = 48'(acc_q >>> 16);
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_ROT_START;
      ST_ROT_START: begin
        cctl = '{start: 1'b1, mode: CM_ROTATE};
        state_d = ST_ROT_WAIT;
      end
      ST_ROT_WAIT: if (cdone) state_d = ST_VEC_START;
      ST_VEC_START: begin
        cctl = '{start: 1'b1, mode: CM_VECTOR};
        state_d = ST_VEC_WAIT;
      end
      ST_VEC_WAIT: if (cdone) begin
        // ex*ex
        mul_a = 33'(ex_q); mul_b = 33'(ex_q);
        acc_d = 96'(mul_p);
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        // ey*ey + ex*ex; stash arrival, then ex*cos
        mul_a = 33'(ey_q); mul_b = 33'(ey_q);
        acc_d = 96'(mul_p) + acc_q;
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        mul_a = 33'(ex_q); mul_b = 33'(cos_q);
        acc_d = 96'(mul_p);
        state_d = ST_MUL_C;
      end
      ST_MUL_C: begin
        mul_a = 33'(ey_q); mul_b = 33'(sin_q);
        acc_d = 96'(mul_p) + acc_q;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_a = projc; mul_b = 33'({1'b0, speed_gain_q});
        acc_d = 96'(mul_p);
        state_d = ST_MUL_E;
      end
      ST_MUL_E: begin
        mul_a = 33'(err32); mul_b = 33'({1'b0, turn_gain_q});
        acc_d = 96'(mul_p);
        tmp_d = (cs_full > 64'sd32767) ? 48'sd32767 :
                (cs_full < -64'sd32768) ? -48'sd32768 : 48'(cs_full);
        state_d = ST_MUL_F;
      end
      ST_MUL_F: begin
        mul_a = 33'({1'b0, tick_q}); mul_b = 33'(rate_q);
        acc_d = 96'(mul_p);
        state_d = ST_MUL_G;
      end
      ST_MUL_G: begin
        // tick*spd, reused for both position increments
        mul_a = 33'({1'b0, tick_q}); mul_b = 33'(spd_q);
        acc_d = 96'(mul_p);
        state_d = ST_MUL_H;
      end
      ST_MUL_H: begin
        mul_a = 33'(acc_q); mul_b = 33'(cos_q);
        acc_d = 96'(mul_p);
        tmp_d = 48'(acc_q);
        state_d = ST_MUL_I;
      end
      ST_MUL_I: begin
        mul_a = 33'(tmp_q); mul_b = 33'(sin_q);
        acc_d = 96'(mul_p);
        state_d = ST_OUT;
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic signed [POS_WIDTH-1:0] pinc;
  assign pinc = POS_WIDTH'(acc_q >>> 46);

  logic signed [63:0] r2;
  assign r2 = 64'({1'b0, radius_q}) * 64'({1'b0, radius_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      dest_x_q     <= '0;
      dest_y_q     <= '0;
      drive_en_q   <= 1'b0;
      speed_gain_q <= 16'd256;
      turn_gain_q  <= 16'd256;
      tick_q       <= 16'd1311;
      radius_q     <= 16'd768;
      pose_x_q     <= '0;
      pose_y_q     <= '0;
      heading_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_if.valid && out_if.ready) out_valid_q <= 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          REG_DEST_X:        dest_x_q     <= cfg_if.data;
          REG_DEST_Y:        dest_y_q     <= cfg_if.data;
          REG_DRIVE_ENABLE:  drive_en_q   <= cfg_if.data[0];
          REG_SPEED_GAIN:    speed_gain_q <= cfg_if.data[15:0];
          REG_TURN_GAIN:     turn_gain_q  <= cfg_if.data[15:0];
          REG_TICK_PERIOD:   tick_q       <= cfg_if.data[15:0];
          REG_ARRIVE_RADIUS: radius_q     <= cfg_if.data[15:0];
          default: ;
        endcase
      end
      // heading is no longer needed by this tick
      if (state_q == ST_MUL_G) heading_q <= heading_q + hinc[15:0];
      if (state_q == ST_MUL_I) pose_x_q <= pose_x_q + pinc;
      if (state_q == ST_OUT) begin
        pose_y_q    <= pose_y_q + pinc;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    tmp_q <= tmp_d;
    if (in_fire) begin
      spd_q  <= in_if.meas_speed;
      rate_q <= in_if.meas_turn_rate;
      ex_q   <= dx_ext - ErrW'(pose_x_q);
      ey_q   <= dy_ext - ErrW'(pose_y_q);
    end
    if (state_q == ST_ROT_WAIT && cdone) begin
      cos_q <= ccos;
      sin_q <= csin;
    end
    if (state_q == ST_MUL_B) reached_q <= acc_q < 96'(r2);
    if (state_q == ST_MUL_F) begin
      cs_q <= drive_en_q ? tmp_q[15:0] : 16'sd0;
      ct_q <= !drive_en_q ? 24'sd0 :
              (ct_full > 64'sd8388607) ? 24'sd8388607 :
              (ct_full < -64'sd8388608) ? -24'sd8388608 : 24'(ct_full);
    end
  end

  assign in_if.ready          = (state_q == ST_IDLE) && !out_valid_q && !cfg_if.valid;
  assign cfg_if.ready         = (state_q == ST_IDLE);
  assign out_if.valid         = out_valid_q;
  assign out_if.cmd_speed     = cs_q;
  assign out_if.cmd_turn_rate = ct_q;
  assign out_if.reached       = reached_q;
  assign out_if.pose_x_out    = 24'(pose_x_q);
  assign out_if.pose_y_out    = 24'(pose_y_q);
  assign out_if.heading_out   = heading_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> state_q == ST_ROT_START)
    else $error("accepted request did not start");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_if.ready)
    else $error("ready while result pending");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result without finished tick");

endmodule

[test/odometry_go_to_point_test.sv]
`timescale 1ns / 1ps
module odometry_go_to_point_test;
  import ogp_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int RandPhases   = 8;
  localparam int PhaseTicks   = 235;
  localparam int HoldCycles   = 400;

  typedef struct {
    logic signed [15:0] cmd_speed;
    logic signed [23:0] cmd_turn;
    logic               reached;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        hdg;
  } tick_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ogp_in_if  in_if ();
  ogp_out_if out_if ();
  ogp_cfg_if cfg_if ();

  odometry_go_to_point dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of configuration and pose
  longint      m_dest_x, m_dest_y;
  logic        m_enable;
  logic [15:0] m_kv, m_kw, m_period, m_radius;
  longint      m_px, m_py;
  logic [15:0] m_hdg;

  tick_res_t tick_q[$];
  int        fails = 0;
  int        sent = 0;
  logic      calm = 1'b0;
  logic      hold_req = 1'b0;

  longint atan_lut [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function automatic longint wrap24(longint v);
    logic [23:0] t;
    t = v[23:0];
    return longint'($signed(t));
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic rotate(input logic [15:0] h, output longint c, output longint s);
    logic [31:0] a;
    logic        neg;
    longint      x, y, z, nx;
    a = {h, 16'h0};
    neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (neg) a = a - 32'h8000_0000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_lut[i];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic logic [31:0] aim_angle(longint xi, longint yi);
    logic [31:0] z;
    longint      x, y, nx;
    if (xi == 0 && yi == 0) return 32'd0;
    z = 32'd0;
    x = xi * 65536;
    y = yi * 65536;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + 32'(atan_lut[i]);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - 32'(atan_lut[i]);
      end
      x = nx;
    end
    return z;
  endfunction

  task automatic predict_tick(input logic signed [15:0] spd, input logic signed [23:0] rate,
                              output tick_res_t r);
    longint      c, s, ex, ey, proj, cs, ct, rad, sp, rt;
    logic [31:0] err;
    rotate(m_hdg, c, s);
    ex = m_dest_x - m_px;
    ey = m_dest_y - m_py;
    rad = longint'(m_radius);
    sp = longint'(spd);
    rt = longint'(rate);
    r.reached = (ex * ex + ey * ey) < rad * rad;
    cs = 0;
    ct = 0;
    if (m_enable) begin
      proj = (ex * c + ey * s) >>> 30;
      cs = clip((proj * longint'(m_kv)) >>> 8, -32768, 32767);
      err = aim_angle(ex, ey) - {m_hdg, 16'h0};
      ct = clip((longint'($signed(err)) * longint'(m_kw)) >>> 24, -8388608, 8388607);
    end
    m_px = wrap24(m_px + ((longint'(m_period) * sp * c) >>> 46));
    m_py = wrap24(m_py + ((longint'(m_period) * sp * s) >>> 46));
    m_hdg = m_hdg + 16'((longint'(m_period) * rt) >>> 16);
    r.cmd_speed = cs[15:0];
    r.cmd_turn = ct[23:0];
    r.pos_x = m_px[23:0];
    r.pos_y = m_py[23:0];
    r.hdg = m_hdg;
  endtask

  // all tasks below start and end at a falling edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_DEST_X:        m_dest_x = longint'($signed(val));
      REG_DEST_Y:        m_dest_y = longint'($signed(val));
      REG_DRIVE_ENABLE:  m_enable = val[0];
      REG_SPEED_GAIN:    m_kv = val[15:0];
      REG_TURN_GAIN:     m_kw = val[15:0];
      REG_TICK_PERIOD:   m_period = val[15:0];
      REG_ARRIVE_RADIUS: m_radius = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic drain();
    while (tick_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tick(input logic signed [15:0] spd, input logic signed [23:0] rate,
                           input logic typed, input tick_res_t fixed);
    tick_res_t r;
    if (!calm && $urandom_range(99) < 37) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.meas_speed = spd;
    in_if.meas_turn_rate = rate;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_tick(spd, rate, r);
    tick_q.push_back(typed ? fixed : r);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [23:0] pick24();
    case ($urandom_range(3))
      0: return 24'h80_0000;
      1: return 24'h7F_FFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick16();
    case ($urandom_range(4))
      0: return 24'h0;
      1: return 24'hFFFF;
      2: return 24'($urandom_range(1, 2047));
      default: return 24'($urandom_range(65535));
    endcase
  endfunction

  // receiver side
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      out_if.ready = calm || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    tick_res_t e;
    if (out_if.valid && out_if.ready) begin
      if (tick_q.size() == 0) begin
        $display("%0t: result with no request pending", $realtime);
        fails++;
      end else begin
        e = tick_q.pop_front();
        if (out_if.cmd_speed !== e.cmd_speed || out_if.cmd_turn_rate !== e.cmd_turn ||
            out_if.reached !== e.reached || out_if.pose_x_out !== e.pos_x ||
            out_if.pose_y_out !== e.pos_y || out_if.heading_out !== e.hdg) begin
          $display("%0t: mismatch exp spd=%0d turn=%0d rch=%0b x=%0d y=%0d h=%0d",
                   $realtime, e.cmd_speed, e.cmd_turn, e.reached, e.pos_x, e.pos_y, e.hdg);
          $display("%0t:          got spd=%0d turn=%0d rch=%0b x=%0d y=%0d h=%0d",
                   $realtime, out_if.cmd_speed, out_if.cmd_turn_rate, out_if.reached,
                   out_if.pose_x_out, out_if.pose_y_out, out_if.heading_out);
          fails++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  // directed rows: speed and turn rate; the first two use a typed expectation
  logic signed [15:0] dir_spd  [16] = '{0, 0, 16'sh7FFF, -16'sh8000, 256, -256, 1, -1,
                                         16'sh7FFF, -16'sh8000, 0, 0, 1000, -1000, 16'sh7FFF, 0};
  logic signed [23:0] dir_rate [16] = '{0, 0, 24'sh7F_FFFF, -24'sh80_0000, 0, 16384, -1, 1,
                                         0, 0, 24'sh7F_FFFF, -24'sh80_0000, 8000, -8000,
                                         24'sh7F_FFFF, 24'sh40_0000};

  initial begin
    tick_res_t fixed, none;
    logic signed [15:0] spd;
    logic signed [23:0] rate;
    in_if.valid = 1'b0;
    in_if.meas_speed = '0;
    in_if.meas_turn_rate = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DEST_X;
    cfg_if.data = '0;
    m_dest_x = 0; m_dest_y = 0; m_enable = 1'b0;
    m_kv = 16'd256; m_kw = 16'd256; m_period = 16'd1311; m_radius = 16'd768;
    m_px = 0; m_py = 0; m_hdg = '0;
    none = '{default: '0};
    // at rest at the origin: zero commands, inside the radius
    fixed = '{cmd_speed: 16'sd0, cmd_turn: 24'sd0, reached: 1'b1,
              pos_x: 24'sd0, pos_y: 24'sd0, hdg: 16'd0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < 8; i++) send_tick(dir_spd[i], dir_rate[i], i < 2, fixed);
    in_if.valid = 1'b0;
    drain();
    write_reg(REG_DRIVE_ENABLE, 24'd1);
    write_reg(REG_DEST_X, 24'h7F_FFFF);
    write_reg(REG_DEST_Y, 24'h80_0000);
    write_reg(REG_SPEED_GAIN, 24'hFFFF);
    write_reg(REG_TURN_GAIN, 24'hFFFF);
    write_reg(REG_TICK_PERIOD, 24'hFFFF);
    write_reg(REG_ARRIVE_RADIUS, 24'hFFFF);
    write_reg(RegUnused, 24'hFF_FFFF);
    for (int i = 8; i < 16; i++) send_tick(dir_spd[i], dir_rate[i], 1'b0, none);
    in_if.valid = 1'b0;
    drain();
    // aim at the current pose: zero errors, bearing taken as zero
    write_reg(REG_DEST_X, 24'(m_px));
    write_reg(REG_DEST_Y, 24'(m_py));
    write_reg(REG_TICK_PERIOD, 24'd0);
    send_tick(16'sh7FFF, 24'sh7F_FFFF, 1'b0, none);
    send_tick(-16'sh8000, -24'sh80_0000, 1'b0, none);
    in_if.valid = 1'b0;

    for (int p = 0; p < RandPhases; p++) begin
      drain();
      write_reg(REG_DRIVE_ENABLE, (p % 4 == 3) ? 24'd0 : 24'd1);
      if ($urandom_range(1) || p == 0) write_reg(REG_DEST_X, pick24());
      if ($urandom_range(1) || p == 0) write_reg(REG_DEST_Y, pick24());
      if ($urandom_range(1) || p == 1) write_reg(REG_SPEED_GAIN, pick16());
      if ($urandom_range(1) || p == 1) write_reg(REG_TURN_GAIN, pick16());
      write_reg(REG_TICK_PERIOD, (p == 2) ? 24'd1 : pick16());
      if ($urandom_range(1) || p == 2) write_reg(REG_ARRIVE_RADIUS, pick16());
      for (int k = 0; k < PhaseTicks; k++) begin
        calm = (sent >= 700 && sent < 950);
        if (sent == 1100) hold_req = 1'b1;
        case ($urandom_range(9))
          0: begin spd = 16'sh7FFF; rate = -24'sh80_0000; end
          1: begin spd = -16'sh8000; rate = 24'sh7F_FFFF; end
          2, 3, 4: begin
            spd = 16'($urandom_range(0, 8191)) - 16'sd4096;
            rate = 24'($urandom_range(0, 65535)) - 24'sd32768;
          end
          default: begin spd = 16'($urandom); rate = 24'($urandom); end
        endcase
        send_tick(spd, rate, 1'b0, none);
      end
      in_if.valid = 1'b0;
    end
    calm = 1'b0;

    fork
      begin
        while (tick_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
      end
    join
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
